// ===== rtl/minimum_spanning_tree_cost_top_assert.svh =====
// ---------------------------------------------------------------------------
// mstc assertion macros
// shorthand for the concurrent checks on the top level ports
// ---------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_COST_TOP_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_COST_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MSTC_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("mstc check failed");

// condition holds in the cycle after the trigger
`define MSTC_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("mstc check failed");

`endif

// ===== rtl/mstc_pkg.sv =====
// ---------------------------------------------------------------------------
// mstc_pkg
// shared sizes, edge record, and controller command/status types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mstc_pkg;

    localparam int MAX_NODES   = 512;
    localparam int MAX_EDGES   = 4096;
    localparam int WEIGHT_W    = 20;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = 10;
    localparam int ADDR_W      = $clog2(MAX_EDGES);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int POS_W       = ADDR_W + 2;
    localparam int COST_W      = 30;
    localparam int EDGE_W      = 2 * NODE_W + WEIGHT_W;
    localparam int IN_TDATA_W  = ((EDGE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COST_W + 2 + 7) / 8) * 8;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   to;
        logic [NODE_W-1:0]   from;
    } t_edge;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_PASS,
        OP_RUN,
        OP_MRD,
        OP_MWR,
        OP_SCANI,
        OP_ECHK,
        OP_STEP,
        OP_ROOTA,
        OP_JOIN,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic pass_more;
        logic run_more;
        logic merge_done;
        logic scan_done;
        logic edge_ok;
        logic par_root;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/mstc_dp.sv =====
// ---------------------------------------------------------------------------
// mstc_dp
// edge stores, merge sort datapath, union-find parent table and cost sum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstc_dp import mstc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_carries,
    input  wire t_edge             i_edge,
    output logic [COST_W-1:0]      o_total_cost,
    output logic                   o_spanning,
    output logic                   o_dropped
);

    t_edge mem_a [MAX_EDGES];
    t_edge mem_b [MAX_EDGES];
    logic [NODE_W-1:0] par [MAX_NODES];

    logic [CNT_W-1:0]  r_ncount;
    logic [FILL_W-1:0] r_fill;
    logic              r_ovf;
    logic              r_src;
    logic [POS_W-1:0]  r_k, r_w, r_base, r_i, r_j, r_le, r_re;
    t_edge             r_a0, r_a1, r_b0, r_b1, r_cur;
    logic [NODE_W-1:0] r_node, r_ra, r_par;
    logic [COST_W-1:0] r_cost;
    logic [CNT_W-1:0]  r_joins;
    logic [COST_W-1:0] r_res_cost;
    logic              r_res_span, r_res_drop;

    logic [CNT_W-1:0]  n_eff;
    logic [POS_W-1:0]  fill_x, run_mid, run_end;
    logic              store_ok, l_ok, r_ok, take_l;
    t_edge             left_e, right_e, taken, sorted;
    logic              a_we, b_we;
    logic [ADDR_W-1:0] w_addr;
    t_edge             w_data;
    logic              p_we;
    logic [NODE_W-1:0] p_addr, p_data;
    logic [COST_W:0]   sum;

    always_comb begin
        if (r_ncount == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_ncount > CNT_W'(MAX_NODES)) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = r_ncount;
        end
    end

    assign fill_x   = POS_W'(r_fill);
    assign run_mid  = r_base + r_w;
    assign run_end  = r_base + (r_w << 1);
    assign store_ok = i_carries && ({1'b0, i_edge.from} < n_eff)
                      && ({1'b0, i_edge.to} < n_eff);

    assign left_e  = r_src ? r_b0 : r_a0;
    assign right_e = r_src ? r_b1 : r_a1;
    assign sorted  = left_e;
    assign l_ok    = r_i < r_le;
    assign r_ok    = r_j < r_re;
    assign take_l  = l_ok && (!r_ok || (left_e.weight <= right_e.weight));
    assign taken   = take_l ? left_e : right_e;

    // store a takes new edges and merges when b is the source
    assign a_we   = ((i_cmd.op == OP_LOAD) && store_ok && (r_fill < FILL_W'(MAX_EDGES)))
                    || ((i_cmd.op == OP_MWR) && r_src);
    assign b_we   = (i_cmd.op == OP_MWR) && !r_src;
    assign w_addr = (i_cmd.op == OP_LOAD) ? r_fill[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign w_data = (i_cmd.op == OP_LOAD) ? i_edge : taken;

    assign p_we   = (i_cmd.op == OP_CLR) || ((i_cmd.op == OP_JOIN) && (r_ra != r_node));
    assign p_addr = (i_cmd.op == OP_CLR) ? r_k[NODE_W-1:0] : r_ra;
    assign p_data = (i_cmd.op == OP_CLR) ? r_k[NODE_W-1:0] : r_node;
    assign sum    = {1'b0, r_cost} + (COST_W+1)'(r_cur.weight);

    always_ff @(posedge i_clk) begin
        r_a0 <= mem_a[r_i[ADDR_W-1:0]];
        r_a1 <= mem_a[r_j[ADDR_W-1:0]];
        if (a_we) begin
            mem_a[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= mem_b[r_i[ADDR_W-1:0]];
        r_b1 <= mem_b[r_j[ADDR_W-1:0]];
        if (b_we) begin
            mem_b[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_par <= par[r_node];
        if (p_we) begin
            par[p_addr] <= p_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= CNT_W'(1);
            r_fill   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ncount <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (store_ok) begin
                        if (r_fill < FILL_W'(MAX_EDGES)) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_k   <= '0;
                    r_w   <= POS_W'(1);
                    r_src <= 1'b0;
                end
                OP_CLR: r_k <= r_k + POS_W'(1);
                OP_PASS: begin
                    r_base <= '0;
                    r_k    <= '0;
                end
                OP_RUN: begin
                    if (r_base < fill_x) begin
                        r_i  <= r_base;
                        r_j  <= run_mid;
                        r_le <= (run_mid < fill_x) ? run_mid : fill_x;
                        r_re <= (run_end < fill_x) ? run_end : fill_x;
                    end else begin
                        r_w   <= r_w << 1;
                        r_src <= !r_src;
                    end
                end
                OP_MRD: begin
                    if (!l_ok && !r_ok) begin
                        r_base <= run_end;
                    end
                end
                OP_MWR: begin
                    r_k <= r_k + POS_W'(1);
                    if (take_l) begin
                        r_i <= r_i + POS_W'(1);
                    end else begin
                        r_j <= r_j + POS_W'(1);
                    end
                end
                OP_SCANI: begin
                    r_i     <= '0;
                    r_cost  <= '0;
                    r_joins <= n_eff - CNT_W'(1);
                end
                OP_ECHK: begin
                    r_cur  <= sorted;
                    r_node <= sorted.from;
                    if (!o_stat.edge_ok) begin
                        r_i <= r_i + POS_W'(1);
                    end
                end
                OP_STEP: r_node <= r_par;
                OP_ROOTA: begin
                    r_ra   <= r_node;
                    r_node <= r_cur.to;
                end
                OP_JOIN: begin
                    if (r_ra != r_node) begin
                        r_cost <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                        if (r_joins != '0) begin
                            r_joins <= r_joins - CNT_W'(1);
                        end
                    end
                    r_i <= r_i + POS_W'(1);
                end
                OP_RESULT: begin
                    r_res_cost <= r_cost;
                    r_res_span <= (r_joins == '0);
                    r_res_drop <= r_ovf;
                    r_fill     <= '0;
                    r_ovf      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.clr_done   = (r_k == POS_W'(MAX_NODES - 1));
        o_stat.pass_more  = (r_w < fill_x);
        o_stat.run_more   = (r_base < fill_x);
        o_stat.merge_done = !l_ok && !r_ok;
        o_stat.scan_done  = (r_i >= fill_x);
        o_stat.edge_ok    = ({1'b0, sorted.from} < n_eff) && ({1'b0, sorted.to} < n_eff);
        o_stat.par_root   = (r_par == r_node);
    end

    assign o_total_cost = r_res_cost;
    assign o_spanning   = r_res_span;
    assign o_dropped    = r_res_drop;

endmodule

`default_nettype wire

// ===== rtl/mstc_ctrl.sv =====
// ---------------------------------------------------------------------------
// mstc_ctrl
// sequencer for load, table clear, merge sort passes and union-find scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstc_ctrl import mstc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_last,
    output logic       o_in_ready,
    input  wire logic  i_out_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_PASS, S_RUN, S_MRD, S_MWR, S_SCANI, S_ERD,
        S_ECHK, S_FA, S_FB, S_GA, S_GB, S_JOIN, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    op = OP_LOAD;
                    if (i_in_last) begin
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                op = OP_CLR;
                if (i_stat.clr_done) begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                op      = OP_PASS;
                n_state = i_stat.pass_more ? S_RUN : S_SCANI;
            end
            S_RUN: begin
                op      = OP_RUN;
                n_state = i_stat.run_more ? S_MRD : S_PASS;
            end
            S_MRD: begin
                op      = OP_MRD;
                n_state = i_stat.merge_done ? S_RUN : S_MWR;
            end
            S_MWR: begin
                op      = OP_MWR;
                n_state = S_MRD;
            end
            S_SCANI: begin
                op      = OP_SCANI;
                n_state = S_ERD;
            end
            S_ERD: n_state = i_stat.scan_done ? S_FIN : S_ECHK;
            S_ECHK: begin
                op      = OP_ECHK;
                n_state = i_stat.edge_ok ? S_FA : S_ERD;
            end
            S_FA: n_state = S_FB;
            S_FB: begin
                if (i_stat.par_root) begin
                    op      = OP_ROOTA;
                    n_state = S_GA;
                end else begin
                    op      = OP_STEP;
                    n_state = S_FA;
                end
            end
            S_GA: n_state = S_GB;
            S_GB: begin
                if (i_stat.par_root) begin
                    n_state = S_JOIN;
                end else begin
                    op      = OP_STEP;
                    n_state = S_GA;
                end
            end
            S_JOIN: begin
                op      = OP_JOIN;
                n_state = S_ERD;
            end
            S_FIN: begin
                // wait for the output slot to be free
                if (!r_ovalid || i_out_ready) begin
                    op      = OP_RESULT;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (op == OP_RESULT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_cmd.op    = op;

endmodule

`default_nettype wire

// ===== rtl/minimum_spanning_tree_cost_top.sv =====
// ---------------------------------------------------------------------------
// minimum_spanning_tree_cost_top
// minimum spanning tree cost of a streamed edge list (merge sort + union-find)
// ---------------------------------------------------------------------------
// usage:
//   node count is written on the cfg channel (always ready) while idle
//   edges arrive on s_axis, one item per cycle while s_axis_tready is high;
//   tuser = 0 gives an empty item, tlast closes the graph
//   after tlast, s_axis_tready stays low during processing:
//     the parent table is reset, then ceil(log2 N) merge sort passes run over
//     the N stored edges, then each stored edge is fetched and range checked,
//     and for an edge in range both root searches walk the parent table
//     before the join
//   the edge memories (one write, two reads per cycle) bound the sort rate
//   one result item appears on m_axis and is held until m_axis_tready;
//   the block returns to loading at that point and takes new edges while
//   the result waits; a second graph is processed as usual, but its result
//   and s_axis_tready stay held until the first result is gone
//   reset clears fill count, overflow flag and sets node count to 1
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module minimum_spanning_tree_cost_top import mstc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // edge_from, edge_to, edge_weight
    input  wire logic                   s_axis_tuser,   // carries_edge
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // total_cost, spanning, edges_dropped
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CNT_W-1:0]       i_cfg_data
);

    t_cmd              cmd;
    t_stat             stat;
    t_edge             in_edge;
    logic [COST_W-1:0] total_cost;
    logic              spanning, dropped;

    assign in_edge     = s_axis_tdata[EDGE_W-1:0];
    assign o_cfg_ready = 1'b1;

    mstc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mstc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_carries    (s_axis_tuser),
        .i_edge       (in_edge),
        .o_total_cost (total_cost),
        .o_spanning   (spanning),
        .o_dropped    (dropped)
    );

    assign m_axis_tdata = OUT_TDATA_W'({dropped, spanning, total_cost});

endmodule

`default_nettype wire

// ===== rtl/mstc_checker.sv =====
// ---------------------------------------------------------------------------
// mstc_checker
// port-level checks on the minimum spanning tree cost block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "minimum_spanning_tree_cost_top_assert.svh"

module mstc_checker import mstc_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   s_axis_tlast,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    `MSTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // closing item starts processing and blocks input
    `MSTC_ASSERT_NEXT(a_last_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

    // input only stops after a closing item
    `MSTC_ASSERT_NOW(a_ready_fall, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tlast))

    // a new result comes with the block back in load mode
    `MSTC_ASSERT_NOW(a_result_load, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind minimum_spanning_tree_cost_top mstc_checker u_mstc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// stream test of minimum_spanning_tree_cost_top: edges are driven on the
// input stream and each graph's cost, spanning and dropped flags are checked
// against a Kruskal predictor kept inside this bench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mstc_pkg::*;

    localparam int IDLE_LIMIT = 40000000;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              spanning;
        logic              dropped;
    } t_mst_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // edge_from, edge_to, edge_weight
    logic                   s_axis_tuser;   // carries_edge
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // total_cost, spanning, edges_dropped
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;

    minimum_spanning_tree_cost_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // predictor state
    logic [CNT_W-1:0]    node_reg;
    logic [NODE_W-1:0]   kept_from [MAX_EDGES];
    logic [NODE_W-1:0]   kept_to   [MAX_EDGES];
    logic [WEIGHT_W-1:0] kept_wt   [MAX_EDGES];
    int                  kept_fill;
    bit                  kept_overflow;
    t_mst_result         cost_expect_q[$];

    int  mismatches;
    int  items_sent;
    int  graphs_checked;
    int  hold_left;
    bit  quiet;
    int  idle_cycles;

    function automatic int active_nodes();
        if (node_reg == 0) return 1;
        if (node_reg > MAX_NODES) return MAX_NODES;
        return node_reg;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int find_root(ref int par[MAX_NODES], input int node);
        int root;
        int nxt;
        root = node;
        while (par[root] != root) root = par[root];
        while (par[node] != root) begin
            nxt = par[node];
            par[node] = root;
            node = nxt;
        end
        return root;
    endfunction

    // kruskal over the stored edges: sort by weight, then join components
    function automatic t_mst_result kruskal_cost();
        int          n;
        int          cnt;
        int          par[MAX_NODES];
        int          ef[MAX_EDGES];
        int          et[MAX_EDGES];
        int          ew[MAX_EDGES];
        int          j;
        int          tf, tt, tw;
        int          ra, rb;
        int          joins;
        longint      sum;
        t_mst_result res;
        n = active_nodes();
        cnt = 0;
        for (int k = 0; k < MAX_NODES; k++) par[k] = k;
        for (int i = 0; i < kept_fill; i++) begin
            if (kept_from[i] < n && kept_to[i] < n) begin
                ef[cnt] = kept_from[i];
                et[cnt] = kept_to[i];
                ew[cnt] = kept_wt[i];
                cnt++;
            end
        end
        for (int i = 1; i < cnt; i++) begin
            tf = ef[i]; tt = et[i]; tw = ew[i];
            j = i;
            while (j > 0 && ew[j-1] > tw) begin
                ef[j] = ef[j-1]; et[j] = et[j-1]; ew[j] = ew[j-1];
                j--;
            end
            ef[j] = tf; et[j] = tt; ew[j] = tw;
        end
        joins = 0;
        sum = 0;
        for (int i = 0; i < cnt; i++) begin
            ra = find_root(par, ef[i]);
            rb = find_root(par, et[i]);
            if (ra != rb) begin
                sum = sum + ew[i];
                if (sum > COST_MAX) sum = COST_MAX;
                par[ra] = rb;
                joins++;
            end
        end
        res.cost = sum[COST_W-1:0];
        res.spanning = (joins >= n - 1);
        res.dropped = kept_overflow;
        return res;
    endfunction

    task automatic predict_item(input bit carries, input int f, input int t, input int w,
                                input bit last);
        int n;
        n = active_nodes();
        if (carries && f < n && t < n) begin
            if (kept_fill < MAX_EDGES) begin
                kept_from[kept_fill] = NODE_W'(f);
                kept_to[kept_fill] = NODE_W'(t);
                kept_wt[kept_fill] = WEIGHT_W'(w);
                kept_fill++;
            end else begin
                kept_overflow = 1'b1;
            end
        end
        if (last) begin
            cost_expect_q.insert(cost_expect_q.size(), kruskal_cost());
            kept_fill = 0;
            kept_overflow = 1'b0;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input bit carries, input int f, input int t, input int w,
                             input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {2'b00, w[WEIGHT_W-1:0], t[NODE_W-1:0], f[NODE_W-1:0]};
        s_axis_tuser  <= carries;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(carries, f, t, w, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (cost_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_node_count(input int n);
        wait_results_done();
        i_cfg_data  <= CNT_W'(n);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        node_reg = CNT_W'(n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random graph over span nodes, optionally seeded with a spanning tree when span <= 48
    task automatic send_graph(input int span, input int extra, input bit tree);
        int  f, t, r;
        int  total;
        int  sent;
        bit  empty_end;
        total = extra + ((tree && span <= 48) ? span - 1 : 0);
        empty_end = ($urandom_range(0, 9) == 0);
        sent = 0;
        if (tree && span <= 48) begin
            for (int i = 1; i < span; i++) begin
                sent++;
                send_item(1'b1, i, $urandom_range(0, i - 1), $urandom_range(0, 4095),
                          sent == total && !empty_end);
            end
        end
        for (int i = 0; i < extra; i++) begin
            sent++;
            r = $urandom_range(0, 99);
            f = $urandom_range(0, span - 1);
            t = $urandom_range(0, span - 1);
            if (r < 5 && span < MAX_NODES) f = $urandom_range(span, MAX_NODES - 1);
            if (r >= 5 && r < 9) begin
                send_item(1'b0, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 1048575), sent == total && !empty_end);
                continue;
            end
            send_item(1'b1, f, t,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048575)
                                                  : $urandom_range(0, 255),
                      sent == total && !empty_end);
        end
        if (empty_end || total == 0)
            send_item(1'b0, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 1048575), 1'b1);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_mst_result got;
        t_mst_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cost     = m_axis_tdata[COST_W-1:0];
            got.spanning = m_axis_tdata[COST_W];
            got.dropped  = m_axis_tdata[COST_W+1];
            if (cost_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: unexpected result cost=%0d span=%0b drop=%0b",
                             got.cost, got.spanning, got.dropped);
            end else begin
                want = cost_expect_q.pop_front();
                graphs_checked++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: graph %0d cost %0d/%0d span %0b/%0b drop %0b/%0b",
                                 graphs_checked, want.cost, got.cost, want.spanning,
                                 got.spanning, want.dropped, got.dropped);
                end
            end
        end
    end

    // result receiver: random stalls plus long hold-offs on request
    always @(negedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            stall = pick_gap();
            m_axis_tready <= (stall == 0);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL minimum_spanning_tree_cost_top");
            $finish;
        end
    end

    task automatic test_directed();
        write_node_count(1);
        send_item(1'b0, 0, 0, 0, 1'b1);                    // empty graph, one node
        write_node_count(4);
        send_item(1'b0, 0, 0, 0, 1'b1);                    // empty graph, no tree
        send_item(1'b1, 0, 1, 1048575, 1'b0);
        send_item(1'b1, 2, 2, 0, 1'b0);                    // self loop
        send_item(1'b1, 7, 1, 5, 1'b0);                    // endpoint out of range
        send_item(1'b0, 511, 511, 1048575, 1'b0);          // empty item
        send_item(1'b1, 1, 2, 0, 1'b0);
        send_item(1'b1, 0, 1, 3, 1'b0);
        send_item(1'b1, 2, 3, 3, 1'b1);                    // edge on the last item
        write_node_count(0);                               // behaves as one node
        send_item(1'b1, 0, 0, 9, 1'b1);
        write_node_count(1023);                            // clamps to full size
        send_item(1'b1, 511, 0, 1048575, 1'b0);
        send_item(1'b1, 0, 511, 1048575, 1'b1);
        write_node_count(512);
        send_item(1'b1, 511, 510, 12345, 1'b1);
    endtask

    // count lowered while edges are stored: the extra edges drop out at compute
    task automatic test_lowered_count();
        write_node_count(10);
        send_item(1'b1, 0, 9, 4, 1'b0);
        send_item(1'b1, 0, 1, 7, 1'b0);
        send_item(1'b1, 1, 2, 2, 1'b0);
        write_node_count(3);
        send_item(1'b0, 0, 0, 0, 1'b1);
    endtask

    task automatic test_store_full();
        write_node_count(16);
        quiet = 1'b1;
        for (int i = 0; i < MAX_EDGES + 6; i++)
            send_item(1'b1, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 1048575), i == MAX_EDGES + 5);
        quiet = 1'b0;
        send_graph(16, 5, 1'b1);                            // flag clears afterwards
    endtask

    // long hold-off spans several graphs so a finished graph waits behind
    // an unread result and the input stalls
    task automatic test_backpressure();
        write_node_count(12);
        hold_left = 20000;
        for (int g = 0; g < 4; g++) send_graph(12, 20, g[0]);
        wait_results_done();
    endtask

    task automatic test_random();
        int span;
        int r;
        while (items_sent < 1500 + MAX_EDGES) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 19);
                if (r == 0) write_node_count(0);
                else if (r == 1) write_node_count(1023);
                else if (r == 2) write_node_count(512);
                else if (r == 3) write_node_count($urandom_range(513, 1022));
                else write_node_count($urandom_range(1, 40));
            end
            span = active_nodes();
            quiet = ($urandom_range(0, 7) == 0);
            send_graph(span, $urandom_range(0, 24), $urandom_range(0, 1));
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        m_axis_tready = 1'b0;
        hold_left = 0;
        quiet = 1'b0;
        mismatches = 0;
        items_sent = 0;
        graphs_checked = 0;
        idle_cycles = 0;
        node_reg = 1;
        kept_fill = 0;
        kept_overflow = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_lowered_count();
        test_store_full();
        test_backpressure();
        test_random();
        wait_results_done();
        repeat (50) @(negedge i_clk);

        $display("covered %0d items in %0d graphs, incl. full store, count clamps, stalls",
                 items_sent, graphs_checked);
        if (mismatches == 0 && cost_expect_q.size() == 0) begin
            $display("PASS minimum_spanning_tree_cost_top");
        end else begin
            $display("mismatches: %0d", mismatches);
            $display("FAIL minimum_spanning_tree_cost_top");
        end
        $finish;
    end

endmodule
